// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/vspc_pkg.sv =====
package vspc_pkg;

    localparam int FIELD_W = 16;
    localparam int ACC_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LO_V  = 8'h76;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_MAJOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MINOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PATCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_OK    = 2'd3;

    localparam logic signed [1:0] ORD_EQUAL      = 2'sb00;
    localparam logic signed [1:0] ORD_REF_NEWER  = 2'sb01;
    localparam logic signed [1:0] ORD_STR_NEWER  = 2'sb11;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_MAJ_FIRST = 3'd1,
        PH_MAJ       = 3'd2,
        PH_MIN_FIRST = 3'd3,
        PH_MIN       = 3'd4,
        PH_PAT_FIRST = 3'd5,
        PH_PAT       = 3'd6,
        PH_DONE      = 3'd7
    } phase_t;

    typedef struct packed {
        logic       is_end;
        logic       is_nul;
        logic       is_v;
        logic       is_dot;
        logic       is_digit;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] major;
        logic [FIELD_W-1:0] minor;
        logic [FIELD_W-1:0] patch;
    } res_t;

endpackage

// ===== src/version_string_parse_compare_unit.sv =====
// channel   | ports                                      | handshake
// ----------+--------------------------------------------+-----------------------
// input     | ch, last                                   | push / full
// result    | order, ok, major_out, minor_out, patch_out | empty / pop
// config    | cfg_index, cfg_data                        | cfg_we, no wait
//
// one character word accepted per cycle while full is low; the ending character
// word passes the character queue and the parser step into the result queue.
// full follows the character queue, empty the result queue; the parser step
// waits when the character queue is empty or the result queue is full.
// order is compared at the result queue head against the reference registers.
// asynchronous active-low reset empties both queues and restarts the parser.
module version_string_parse_compare_unit #(
    parameter int TOK_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         ch,
    input  logic                               last,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [1:0]                  order,
    output logic                               ok,
    output logic [vspc_pkg::FIELD_W-1:0]       major_out,
    output logic [vspc_pkg::FIELD_W-1:0]       minor_out,
    output logic [vspc_pkg::FIELD_W-1:0]       patch_out,
    input  logic                               cfg_we,
    input  logic [vspc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vspc_pkg::FIELD_W-1:0]       cfg_data
);
    import vspc_pkg::*;

    `include "assert_macros.svh"

    tok_t               tok_in;
    tok_t               tok_out;
    logic               tok_wr;
    logic               tok_rd;
    logic               tok_empty;
    logic [$bits(tok_t)-1:0] tok_raw;
    res_t               res_in;
    res_t               res_head;
    logic               res_wr;
    logic               res_full;
    logic [$bits(res_t)-1:0] res_raw;
    logic [FIELD_W-1:0] ref_major_reg;
    logic [FIELD_W-1:0] ref_minor_reg;
    logic [FIELD_W-1:0] ref_patch_reg;
    logic               ref_ok_reg;

    vspc_front u_front (
        .push     (push),
        .ch       (ch),
        .last     (last),
        .tok_full (full),
        .tok_wr   (tok_wr),
        .tok      (tok_in)
    );

    vspc_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_wr),
        .wr_data (tok_in),
        .rd_en   (tok_rd),
        .rd_data (tok_raw),
        .full    (full),
        .empty   (tok_empty)
    );

    assign tok_out = tok_t'(tok_raw);

    vspc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_rd    (tok_rd),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res_in)
    );

    vspc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_raw),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_head  = res_t'(res_raw);
    assign ok        = res_head.ok;
    assign major_out = res_head.major;
    assign minor_out = res_head.minor;
    assign patch_out = res_head.patch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_major_reg <= '0;
            ref_minor_reg <= '0;
            ref_patch_reg <= '0;
            ref_ok_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REF_MAJOR: ref_major_reg <= cfg_data;
                CFG_REF_MINOR: ref_minor_reg <= cfg_data;
                CFG_REF_PATCH: ref_patch_reg <= cfg_data;
                CFG_REF_OK:    ref_ok_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (!(ref_ok_reg && res_head.ok))
        begin
            order = ORD_EQUAL;
        end
        else if (ref_major_reg != res_head.major)
        begin
            order = (ref_major_reg > res_head.major) ? ORD_REF_NEWER : ORD_STR_NEWER;
        end
        else if (ref_minor_reg != res_head.minor)
        begin
            order = (ref_minor_reg > res_head.minor) ? ORD_REF_NEWER : ORD_STR_NEWER;
        end
        else if (ref_patch_reg != res_head.patch)
        begin
            order = (ref_patch_reg > res_head.patch) ? ORD_REF_NEWER : ORD_STR_NEWER;
        end
        else
        begin
            order = ORD_EQUAL;
        end
    end

    `ASSERT_ALWAYS(a_invalid_equal, empty || ok || order == ORD_EQUAL,
                   "ordering given for an invalid word")

endmodule

// ===== src/vspc_fifo.sv =====
`include "assert_macros.svh"

module vspc_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "fifo count past depth")
    `ASSERT_NEXT(a_count_step, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1,
                 "fifo count did not advance on write")

endmodule

// ===== src/vspc_front.sv =====
module vspc_front (
    input  logic           push,
    input  logic [7:0]     ch,
    input  logic           last,
    input  logic           tok_full,
    output logic           tok_wr,
    output vspc_pkg::tok_t tok
);
    import vspc_pkg::*;

    // character classification
    always_comb
    begin
        tok          = '0;
        tok.is_nul   = (ch == CH_NUL);
        tok.is_end   = (ch == CH_NUL) || last;
        tok.is_v     = (ch == CH_LO_V) || (ch == CH_UP_V);
        tok.is_dot   = (ch == CH_DOT);
        tok.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        tok.digit    = tok.is_digit ? ch[3:0] : 4'd0;
    end

    assign tok_wr = push && !tok_full;

endmodule

// ===== src/vspc_back.sv =====
`include "assert_macros.svh"

module vspc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  vspc_pkg::tok_t tok,
    input  logic           tok_empty,
    output logic           tok_rd,
    input  logic           res_full,
    output logic           res_wr,
    output vspc_pkg::res_t res
);
    import vspc_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [ACC_W-1:0]   accum_reg;
    logic [ACC_W-1:0]   accum_next;
    logic [FIELD_W-1:0] major_reg;
    logic [FIELD_W-1:0] major_next;
    logic [FIELD_W-1:0] minor_reg;
    logic [FIELD_W-1:0] minor_next;
    logic [FIELD_W-1:0] patch_reg;
    logic [FIELD_W-1:0] patch_next;
    logic               ok_reg;
    logic               ok_next;
    logic [19:0]        prod;
    logic [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]   acc_digit;

    assign tok_rd    = !tok_empty && !res_full;
    assign prod      = 20'(accum_reg) * 20'd10 + 20'(tok.digit);
    assign acc_sat   = (prod > 20'(ACC_SAT)) ? ACC_SAT : prod[ACC_W-1:0];
    assign acc_digit = ACC_W'(tok.digit);

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        patch_next = patch_reg;
        ok_next    = ok_reg;
        res_wr     = 1'b0;
        res        = '0;
        if (tok_rd)
        begin
            if (!tok.is_nul)
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (tok.is_v)
                        begin
                            phase_next = PH_MAJ_FIRST;
                        end
                        else if (tok.is_digit)
                        begin
                            accum_next = acc_digit;
                            phase_next = PH_MAJ;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST:
                    begin
                        if (tok.is_digit)
                        begin
                            accum_next = acc_digit;
                            unique case (phase_reg)
                                PH_MAJ_FIRST: phase_next = PH_MAJ;
                                PH_MIN_FIRST: phase_next = PH_MIN;
                                default:      phase_next = PH_PAT;
                            endcase
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_MAJ, PH_MIN:
                    begin
                        if (tok.is_digit)
                        begin
                            accum_next = acc_sat;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            if (!accum_reg[ACC_W-1])
                            begin
                                if (phase_reg == PH_MAJ)
                                begin
                                    major_next = accum_reg[FIELD_W-1:0];
                                end
                                else
                                begin
                                    minor_next = accum_reg[FIELD_W-1:0];
                                end
                                if (tok.is_dot)
                                begin
                                    accum_next = '0;
                                    phase_next = (phase_reg == PH_MAJ) ? PH_MIN_FIRST
                                                                       : PH_PAT_FIRST;
                                end
                            end
                        end
                    end
                    PH_PAT:
                    begin
                        if (tok.is_digit)
                        begin
                            accum_next = acc_sat;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            if (!accum_reg[ACC_W-1])
                            begin
                                patch_next = accum_reg[FIELD_W-1:0];
                                ok_next    = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (tok.is_end)
            begin
                // field digits running into end of string
                if (!accum_next[ACC_W-1])
                begin
                    unique case (phase_next)
                        PH_MAJ: major_next = accum_next[FIELD_W-1:0];
                        PH_MIN: minor_next = accum_next[FIELD_W-1:0];
                        PH_PAT:
                        begin
                            patch_next = accum_next[FIELD_W-1:0];
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                res_wr     = 1'b1;
                res.ok     = ok_next;
                res.major  = major_next;
                res.minor  = minor_next;
                res.patch  = patch_next;
                phase_next = PH_START;
                accum_next = '0;
                major_next = '0;
                minor_next = '0;
                patch_next = '0;
                ok_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            accum_reg <= '0;
            major_reg <= '0;
            minor_reg <= '0;
            patch_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
            patch_reg <= patch_next;
            ok_reg    <= ok_next;
        end
    end

    `ASSERT_NEXT(a_end_restarts, tok_rd && tok.is_end,
                 phase_reg == PH_START && accum_reg == '0 && !ok_reg,
                 "parser not cleared after end of string")
    `ASSERT_ALWAYS(a_ok_in_done, !ok_reg || phase_reg == PH_DONE,
                   "valid flag set before patch completed")

endmodule

// ===== sim/tb_version_string_parse_compare_unit.sv =====
module tb_version_string_parse_compare_unit;

    import vspc_pkg::*;

    typedef struct packed {
        logic [1:0]         ord;
        logic               ok;
        logic [FIELD_W-1:0] major;
        logic [FIELD_W-1:0] minor;
        logic [FIELD_W-1:0] patch;
    } version_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           ch = 8'd0;
    logic                 last = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [1:0]    order;
    logic                 ok;
    logic [FIELD_W-1:0]   major_out;
    logic [FIELD_W-1:0]   minor_out;
    logic [FIELD_W-1:0]   patch_out;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_REF_MAJOR;
    logic [FIELD_W-1:0]   cfg_data = '0;

    version_t pending_versions[$];
    logic [7:0] text_buf[$];

    // reference registers as the order comparison sees them
    logic [FIELD_W-1:0] base_major = '0;
    logic [FIELD_W-1:0] base_minor = '0;
    logic [FIELD_W-1:0] base_patch = '0;
    logic               base_valid = 1'b0;

    // parser state
    phase_t             scan_phase = PH_START;
    logic [ACC_W-1:0]   digit_acc = '0;
    logic [FIELD_W-1:0] got_major = '0;
    logic [FIELD_W-1:0] got_minor = '0;
    logic [FIELD_W-1:0] got_patch = '0;
    logic               got_ok = 1'b0;

    bit sender_idles = 1'b1;
    bit reader_idles = 1'b1;
    int chars_sent = 0;
    int mismatches = 0;

    version_string_parse_compare_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .ch        (ch),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .order     (order),
        .ok        (ok),
        .major_out (major_out),
        .minor_out (minor_out),
        .patch_out (patch_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit commit_field();
        if (digit_acc >= ACC_SAT)
            return 1'b0;
        if (scan_phase == PH_MAJ)
            got_major = digit_acc[FIELD_W-1:0];
        else if (scan_phase == PH_MIN)
            got_minor = digit_acc[FIELD_W-1:0];
        else if (scan_phase == PH_PAT)
        begin
            got_patch = digit_acc[FIELD_W-1:0];
            got_ok = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        bit is_digit;
        logic [3:0] d;
        int unsigned v;
        bit committed;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        v = 32'(digit_acc) * 32'd10 + 32'(d);
        case (scan_phase)
            PH_START:
            begin
                if (c == CH_LO_V || c == CH_UP_V)
                    scan_phase = PH_MAJ_FIRST;
                else if (is_digit)
                begin
                    digit_acc = ACC_W'(d);
                    scan_phase = PH_MAJ;
                end
                else
                    scan_phase = PH_DONE;
            end
            PH_MAJ_FIRST, PH_MIN_FIRST, PH_PAT_FIRST:
            begin
                if (is_digit)
                begin
                    digit_acc = ACC_W'(d);
                    scan_phase = phase_t'(scan_phase + 3'd1);
                end
                else
                    scan_phase = PH_DONE;
            end
            PH_MAJ, PH_MIN, PH_PAT:
            begin
                if (is_digit)
                    digit_acc = (v > 32'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
                else
                begin
                    committed = commit_field();
                    if (committed && c == CH_DOT && scan_phase != PH_PAT)
                    begin
                        digit_acc = '0;
                        scan_phase = phase_t'(scan_phase + 3'd1);
                    end
                    else
                        scan_phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void track_char(logic [7:0] c, logic l);
        version_t v;
        if (c != CH_NUL)
            scan_char(c);
        if (c == CH_NUL || l)
        begin
            if (scan_phase == PH_MAJ || scan_phase == PH_MIN || scan_phase == PH_PAT)
                void'(commit_field());
            v.ord = ORD_EQUAL;
            if (base_valid && got_ok)
            begin
                if (base_major != got_major)
                    v.ord = (base_major > got_major) ? ORD_REF_NEWER : ORD_STR_NEWER;
                else if (base_minor != got_minor)
                    v.ord = (base_minor > got_minor) ? ORD_REF_NEWER : ORD_STR_NEWER;
                else if (base_patch != got_patch)
                    v.ord = (base_patch > got_patch) ? ORD_REF_NEWER : ORD_STR_NEWER;
            end
            v.ok = got_ok;
            v.major = got_major;
            v.minor = got_minor;
            v.patch = got_patch;
            pending_versions.push_back(v);
            scan_phase = PH_START;
            digit_acc = '0;
            got_major = '0;
            got_minor = '0;
            got_patch = '0;
            got_ok = 1'b0;
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        version_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_versions.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0d.%0d.%0d ok %0d",
                         $time, major_out, minor_out, patch_out, ok);
                mismatches++;
            end
            else
            begin
                want = pending_versions.pop_front();
                check_field("order", want.ord, $unsigned(order));
                check_field("ok", want.ok, ok);
                check_field("major", want.major, major_out);
                check_field("minor", want.minor, minor_out);
                check_field("patch", want.patch, patch_out);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= reader_idles ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] c, input logic l);
        while (sender_idles && $urandom_range(0, 99) < 37)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        ch <= c;
        last <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        track_char(c, l);
        chars_sent++;
        @(negedge clk);
    endtask

    // end_style: 0 last flag on final char, 1 nul, 2 nul with last flag
    task automatic send_text(input int end_style);
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], end_style == 0 && i == text_buf.size() - 1);
        if (end_style != 0)
            send_char(CH_NUL, end_style == 2);
    endtask

    task automatic put_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic put_dec(input int unsigned value);
        logic [7:0] digs[$];
        int unsigned x;
        x = value;
        do
        begin
            digs.push_front(CH_ZERO + 8'(x % 10));
            x = x / 10;
        end
        while (x != 0);
        foreach (digs[i])
            text_buf.push_back(digs[i]);
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        @(negedge clk);
        while (pending_versions.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_reference(input logic [FIELD_W-1:0] maj, input logic [FIELD_W-1:0] mnr,
                                 input logic [FIELD_W-1:0] pat, input logic valid);
        cfg_we <= 1'b1;
        cfg_index <= CFG_REF_MAJOR;
        cfg_data <= maj;
        @(negedge clk);
        cfg_index <= CFG_REF_MINOR;
        cfg_data <= mnr;
        @(negedge clk);
        cfg_index <= CFG_REF_PATCH;
        cfg_data <= pat;
        @(negedge clk);
        cfg_index <= CFG_REF_OK;
        cfg_data <= FIELD_W'(valid);
        @(negedge clk);
        cfg_we <= 1'b0;
        base_major = maj;
        base_minor = mnr;
        base_patch = pat;
        base_valid = valid;
    endtask

    function automatic int unsigned pick_field(input logic [FIELD_W-1:0] base);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return base;
            4:          return base + 1;
            5:          return (base == 0) ? 0 : base - 1;
            6, 7:       return $urandom_range(0, 20);
            8:          return $urandom_range(0, 65535);
            default:    return $urandom_range(65536, 999999);
        endcase
    endfunction

    task automatic send_random_version();
        logic [FIELD_W-1:0] bases[3];
        int unsigned pos;
        bases[0] = base_major;
        bases[1] = base_minor;
        bases[2] = base_patch;
        text_buf.delete();
        case ($urandom_range(0, 2))
            1: text_buf.push_back(CH_LO_V);
            2: text_buf.push_back(CH_UP_V);
            default:
            begin
            end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                text_buf.push_back(CH_ZERO);
            put_dec(pick_field(bases[k]));
            if (k < 2)
                text_buf.push_back(CH_DOT);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(0, text_buf.size() - 1);
            text_buf[pos] = 8'($urandom_range(0, 255));
        end
        send_text($urandom_range(0, 2));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_reset_reference();
        // reference invalid after reset, order stays equal
        put_text("V1.2.3");
        send_text(0);
        wait_all_results();
    endtask

    task automatic test_string_endings();
        set_reference(16'd9, 16'd8, 16'd7, 1'b1);
        send_char(CH_NUL, 1'b1);
        put_text("9.8.7x");
        send_text(1);
        wait_all_results();
    endtask

    task automatic test_field_limits();
        set_reference(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // major at maximum, minor saturates
        put_text("65535.65536");
        send_text(0);
        wait_all_results();
    endtask

    task automatic test_random_versions();
        int target;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: set_reference(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                                 16'($urandom_range(0, 20)), 1'b1);
                1: set_reference(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                2: set_reference(16'h0000, 16'h0000, 16'h0000, 1'b0);
                default: set_reference(16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 20)),
                                       16'($urandom_range(0, 65535)), 1'b1);
            endcase
            sender_idles = (p != 2);
            reader_idles = (p != 2);
            target = chars_sent + 175;
            while (chars_sent < target)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                else
                    send_random_version();
            end
            wait_all_results();
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_reference();
        test_string_endings();
        test_field_limits();
        test_random_versions();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/vspc_pkg.sv
src/vspc_fifo.sv
src/vspc_front.sv
src/vspc_back.sv
src/version_string_parse_compare_unit.sv
sim/tb_version_string_parse_compare_unit.sv
